### sv/btbn_pkg.sv
// Shared types and constants for the binary-tree barrier node.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package btbn_pkg;

  // Largest node count that takes part in the barrier.
  localparam int MAX_NODES = 256;

  localparam int ID_W  = 8;  // node_id register and dest_node field
  localparam int CNT_W = 9;  // node_count register
  localparam int CFG_W = 9;  // widest register
  localparam int IDX_W = 1;  // register index

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_NODE_ID    = 1'd0;
  localparam logic [IDX_W-1:0] REG_NODE_COUNT = 1'd1;

  // Input operations.
  localparam logic OP_POLL  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_MSG      = 2'd0;
  localparam logic [1:0] KIND_NOT_YET  = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;

  // Flag values.
  localparam logic [1:0] FLAG_CLEAR   = 2'd0;
  localparam logic [1:0] FLAG_ARRIVED = 2'd1;
  localparam logic [1:0] FLAG_RELEASE = 2'd2;

  // Everything the back end needs to emit the results of one poll.
  typedef struct packed {
    logic            msg_parent;
    logic            msg_child0;
    logic            msg_child1;
    logic            done;         // final result is complete, else not yet
    logic [ID_W-1:0] parent_node;
    logic [1:0]      parent_slot;
    logic [ID_W-1:0] child0_node;
    logic [ID_W-1:0] child1_node;
    logic [1:0]      base_slot;
  } plan_t;

endpackage

`default_nettype wire

### sv/btbn_front.sv
// Front end of the barrier node: configuration, flag banks and barrier state.
// Classifies each beat and turns a poll into a result plan. Uses btbn_pkg.
`default_nettype none

module btbn_front import btbn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             accept,
  input  wire logic             operation,
  input  wire logic [1:0]       flag_slot,
  input  wire logic [1:0]       flag_value,
  output plan_t                 plan,
  output logic                  push
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

  logic [ID_W-1:0]  node_id;
  logic [CNT_W-1:0] node_count;
  logic [1:0]       flags [4];
  logic             sense;
  logic             phase;
  logic             resume_child;

  logic [CNT_W-1:0] cnt_eff;
  logic [ID_W+1:0]  child0;
  logic [ID_W+1:0]  child1;
  logic             present0;
  logic             present1;
  logic [1:0]       f0;
  logic [1:0]       f1;
  logic             miss0_first;
  logic             miss1;
  logic             red_block;
  logic             is_root;
  logic             released;
  logic             bcast;
  logic [ID_W-1:0]  me_m1;

  always_comb begin
    cnt_eff  = (node_count > MAX_CNT) ? MAX_CNT : node_count;
    child0   = {1'b0, node_id, 1'b1};
    child1   = child0 + (ID_W+2)'(1);
    present0 = child0 < {1'b0, cnt_eff};
    present1 = child1 < {1'b0, cnt_eff};
    f0       = flags[{sense, 1'b0}];
    f1       = flags[{sense, 1'b1}];
    is_root  = (node_id == '0);
    me_m1    = node_id - ID_W'(1);

    // A reduce resumes at the child recorded by the last waiting poll.
    miss0_first = !resume_child && present0 && (f0 != FLAG_ARRIVED);
    miss1       = present1 && (f1 != FLAG_ARRIVED);
    red_block   = !phase && (miss0_first || miss1);
    released    = is_root || (f0 == FLAG_RELEASE);
    bcast       = !red_block && released;

    plan.msg_parent  = !phase && !red_block && !is_root;
    plan.msg_child0  = bcast && present0;
    plan.msg_child1  = bcast && present1;
    plan.done        = bcast;
    plan.parent_node = {1'b0, me_m1[ID_W-1:1]};
    plan.parent_slot = {sense, me_m1[0]};
    plan.child0_node = child0[ID_W-1:0];
    plan.child1_node = child1[ID_W-1:0];
    plan.base_slot   = {sense, 1'b0};

    push = accept && (operation == OP_POLL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id      <= '0;
      node_count   <= CNT_W'(1);
      for (int i = 0; i < 4; i++) flags[i] <= FLAG_CLEAR;
      sense        <= 1'b0;
      phase        <= 1'b0;
      resume_child <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_ID:    node_id    <= cfg_data[ID_W-1:0];
          REG_NODE_COUNT: node_count <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (accept && (operation == OP_WRITE)) begin
        flags[flag_slot] <= flag_value;
      end else if (push) begin
        if (red_block) begin
          resume_child <= !miss0_first;
        end else if (!released) begin
          phase <= 1'b1;
        end else begin
          phase                 <= 1'b0;
          resume_child          <= 1'b0;
          flags[{sense, 1'b0}]  <= FLAG_CLEAR;
          flags[{sense, 1'b1}]  <= FLAG_CLEAR;
          sense                 <= !sense;
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/btbn_queue.sv
// Short queue of poll plans between the front and the back end.
// Holds up to QUEUE_DEPTH plans. Uses btbn_pkg.
`default_nettype none

module btbn_queue import btbn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  plan_t     push_plan,
  output logic      full,
  output logic      head_valid,
  output plan_t     head_plan,
  input  wire logic pop
);

  plan_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_comb begin
    full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
    head_valid = (count != '0);
    head_plan  = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_plan;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/btbn_back.sv
// Back end of the barrier node: walks the head plan into the output register, one result
// per cycle while m_tready does not stall the output. Uses btbn_pkg.
`default_nettype none

module btbn_back import btbn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  plan_t            head_plan,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  logic            sent_parent;
  logic            sent_child0;
  logic            sent_child1;
  logic            load;
  logic            pick_parent;
  logic            pick_child0;
  logic            pick_child1;
  logic [1:0]      kind_next;
  logic [ID_W-1:0] node_next;
  logic [1:0]      slot_next;
  logic [1:0]      value_next;

  always_comb begin
    load        = head_valid && (!m_tvalid || m_tready);
    pick_parent = head_plan.msg_parent && !sent_parent;
    pick_child0 = !pick_parent && head_plan.msg_child0 && !sent_child0;
    pick_child1 = !pick_parent && !pick_child0 && head_plan.msg_child1 && !sent_child1;
    pop         = load && !pick_parent && !pick_child0 && !pick_child1;

    kind_next  = head_plan.done ? KIND_COMPLETE : KIND_NOT_YET;
    node_next  = '0;
    slot_next  = '0;
    value_next = FLAG_CLEAR;
    if (pick_parent) begin
      kind_next  = KIND_MSG;
      node_next  = head_plan.parent_node;
      slot_next  = head_plan.parent_slot;
      value_next = FLAG_ARRIVED;
    end else if (pick_child0 || pick_child1) begin
      kind_next  = KIND_MSG;
      node_next  = pick_child0 ? head_plan.child0_node : head_plan.child1_node;
      slot_next  = head_plan.base_slot;
      value_next = FLAG_RELEASE;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {4'b0, value_next, slot_next, node_next};
      m_tuser <= kind_next;
      m_tlast <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      sent_parent <= 1'b0;
      sent_child0 <= 1'b0;
      sent_child1 <= 1'b0;
    end else begin
      if (load)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (pop) begin
        sent_parent <= 1'b0;
        sent_child0 <= 1'b0;
        sent_child1 <= 1'b0;
      end else if (load) begin
        if (pick_parent) sent_parent <= 1'b1;
        if (pick_child0) sent_child0 <= 1'b1;
        if (pick_child1) sent_child1 <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/binary_tree_barrier_node_core.sv
// A poll's plan is registered in the plan queue, then each result in the output register.
// Remote flag writes are taken every cycle while the plan queue has room; a poll holds the
// output sequencer for each of its results (one to four).
// The four-entry plan queue lets input beats continue while results wait on m_tready.
// Reset (rst, synchronous): flags, sense, phase and resume point clear, node_id is 0,
// node_count is 1 and the queue and output register empty.
`default_nettype none

module binary_tree_barrier_node_core import btbn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // [1:0] flag_slot, [3:2] flag_value
  input  wire logic             s_tuser,   // [0] operation
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [15:0]           m_tdata,   // [7:0] dest_node, [9:8] dest_slot, [11:10] msg_value
  output logic [1:0]            m_tuser,   // [1:0] kind
  output logic                  m_tlast
);

  plan_t plan;
  plan_t head_plan;
  logic  push;
  logic  full;
  logic  head_valid;
  logic  pop;
  logic  accept;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  btbn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .operation  (s_tuser),
    .flag_slot  (s_tdata[1:0]),
    .flag_value (s_tdata[3:2]),
    .plan       (plan),
    .push       (push)
  );

  btbn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_plan  (plan),
    .full       (full),
    .head_valid (head_valid),
    .head_plan  (head_plan),
    .pop        (pop)
  );

  btbn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_plan  (head_plan),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

### sv/btbn_checker.sv
// Port-level checks for the barrier node, attached to the top level by bind.
// Uses btbn_pkg for result kinds and flag values.
`default_nettype none

module btbn_checker import btbn_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  // Only messages continue a poll; status beats always end it.
  a_last_on_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != KIND_MSG)))
    else $error("tlast does not match result kind");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_MSG || m_tuser == KIND_NOT_YET ||
                  m_tuser == KIND_COMPLETE))
    else $error("illegal result kind");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_MSG) |-> (m_tdata == 16'd0))
    else $error("status beat carries message data");

  a_msg_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_MSG) |->
      (m_tdata[11:10] == FLAG_ARRIVED || m_tdata[11:10] == FLAG_RELEASE))
    else $error("message value is neither arrival nor release");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("stalled output beat changed");

endmodule

bind binary_tree_barrier_node_core btbn_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

### test/binary_tree_barrier_node_core_test.sv
// Self-checking testbench for binary_tree_barrier_node_core: a directed table, then random
// barrier episodes, all checked beat by beat against a behavioral model of one tree node.
// Depends on btbn_pkg and the core RTL only.
`default_nettype none

module binary_tree_barrier_node_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import btbn_pkg::*;

  localparam int RANDOM_ITEMS  = 146;
  localparam int CALM_ITEMS    = 30;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 1000;

  localparam logic PHASE_REDUCE    = 1'b0;
  localparam logic PHASE_BROADCAST = 1'b1;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] dest_node;
    logic [1:0]      dest_slot;
    logic [1:0]      msg_value;
    logic            last;
  } beat_t;

  typedef struct {
    bit               is_cfg;
    logic             op;
    logic [1:0]       slot;
    logic [1:0]       value;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
    bit               typed;
    logic [1:0]       typed_kind;
  } row_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata   = '0;  // [1:0] flag_slot, [3:2] flag_value
  logic             s_tuser   = 1'b0; // [0] operation
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [15:0]      m_tdata;         // [7:0] dest_node, [9:8] dest_slot, [11:10] msg_value
  logic [1:0]       m_tuser;         // [1:0] kind
  logic             m_tlast;

  // Model copy of the node: configuration and barrier state.
  logic [ID_W-1:0]  node_id_q    = '0;
  logic [CNT_W-1:0] node_count_q = 9'd1;
  logic [1:0]       flags_q [4];
  logic             sense_q  = 1'b0;
  logic             phase_q  = PHASE_REDUCE;
  logic             resume_q = 1'b0;

  beat_t pending_beats[$];
  row_t  directed_rows[$];

  int errors           = 0;
  int items_sent       = 0;
  int polls_sent       = 0;
  int settings_used    = 0;
  int beats_seen       = 0;
  int completions_seen = 0;
  int stall_left       = 0;
  int idle_cycles      = 0;
  bit calm             = 1'b0;

  binary_tree_barrier_node_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #2 clk = ~clk;

  function automatic beat_t make_beat(logic [1:0] kind, logic [ID_W-1:0] node,
                                      logic [1:0] slot, logic [1:0] value, logic last);
    beat_t b;
    b.kind      = kind;
    b.dest_node = node;
    b.dest_slot = slot;
    b.msg_value = value;
    b.last      = last;
    return b;
  endfunction

  function automatic string beat_text(beat_t b);
    return $sformatf("kind %0d node %0d slot %0d value %0d last %0d",
                     b.kind, b.dest_node, b.dest_slot, b.msg_value, b.last);
  endfunction

  function automatic int unsigned active_count();
    return (node_count_q > MAX_NODES) ? MAX_NODES : node_count_q;
  endfunction

  function automatic row_t item_row(logic op, logic [1:0] slot, logic [1:0] value);
    row_t r;
    r = '{default: '0};
    r.op    = op;
    r.slot  = slot;
    r.value = value;
    return r;
  endfunction

  function automatic row_t typed_poll_row(logic [1:0] kind);
    row_t r;
    r = item_row(OP_POLL, 2'd0, 2'd0);
    r.typed      = 1'b1;
    r.typed_kind = kind;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [ID_W-1:0] id, logic [CNT_W-1:0] count);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.id     = id;
    r.count  = count;
    return r;
  endfunction

  // Applies one input beat to the model node and queues the result beats it causes.
  task automatic barrier_node_step(logic op, logic [1:0] slot, logic [1:0] value);
    int unsigned me, n, base, child, i;
    me   = node_id_q;
    n    = active_count();
    base = sense_q ? 2 : 0;
    if (op == OP_WRITE) begin
      flags_q[slot] = value;
      return;
    end
    if (phase_q == PHASE_REDUCE) begin
      // Children already seen on an earlier poll are not checked again.
      for (i = resume_q; i < 2; i++) begin
        child = 2 * me + 1 + i;
        if (child < n && flags_q[base + i] != FLAG_ARRIVED) begin
          resume_q = (i != 0);
          pending_beats.push_back(make_beat(KIND_NOT_YET, '0, 2'd0, FLAG_CLEAR, 1'b1));
          return;
        end
      end
      if (me != 0)
        pending_beats.push_back(make_beat(KIND_MSG, ID_W'((me - 1) / 2),
                                          2'(base + (me - 1) % 2), FLAG_ARRIVED, 1'b0));
      phase_q = PHASE_BROADCAST;
    end
    if (me != 0 && flags_q[base] != FLAG_RELEASE) begin
      pending_beats.push_back(make_beat(KIND_NOT_YET, '0, 2'd0, FLAG_CLEAR, 1'b1));
      return;
    end
    for (i = 0; i < 2; i++) begin
      child = 2 * me + 1 + i;
      if (child < n)
        pending_beats.push_back(make_beat(KIND_MSG, ID_W'(child), 2'(base), FLAG_RELEASE,
                                          1'b0));
    end
    phase_q           = PHASE_REDUCE;
    resume_q          = 1'b0;
    flags_q[base]     = FLAG_CLEAR;
    flags_q[base + 1] = FLAG_CLEAR;
    sense_q           = ~sense_q;
    pending_beats.push_back(make_beat(KIND_COMPLETE, '0, 2'd0, FLAG_CLEAR, 1'b1));
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken,
  // with s_tvalid still high so that a following beat can go out back to back.
  task automatic send_item(logic op, logic [1:0] slot, logic [1:0] value,
                           bit typed, logic [1:0] typed_kind);
    int depth_now;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, value, slot};
    depth_now = pending_beats.size();
    barrier_node_step(op, slot, value);
    if (typed) begin
      while (pending_beats.size() > depth_now) void'(pending_beats.pop_back());
      pending_beats.push_back(make_beat(typed_kind, '0, 2'd0, FLAG_CLEAR, 1'b1));
    end
    items_sent++;
    if (op == OP_POLL) polls_sent++;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Stops the sender until every expected beat is out and the core has settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure_node(logic [ID_W-1:0] id, logic [CNT_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NODE_ID;
    cfg_data  <= {1'b0, id};
    @(negedge clk);
    cfg_index <= REG_NODE_COUNT;
    cfg_data  <= count;
    @(negedge clk);
    cfg_we <= 1'b0;
    node_id_q    = id;
    node_count_q = count;
    settings_used++;
  endtask

  // One barrier round as the neighbors would drive it, with occasional early polls,
  // wrong flag values, or plain noise instead.
  task automatic run_episode();
    int unsigned me, n, base, i;
    me   = node_id_q;
    n    = active_count();
    base = sense_q ? 2 : 0;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4))
        send_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)), 1'b0, KIND_MSG);
      return;
    end
    for (i = 0; i < 2; i++) begin
      if (2 * me + 1 + i < n) begin
        if ($urandom_range(0, 4) == 0)
          send_item(OP_POLL, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b0,
                    KIND_MSG);
        send_item(OP_WRITE, 2'(base + i),
                  ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : FLAG_ARRIVED,
                  1'b0, KIND_MSG);
      end
    end
    send_item(OP_POLL, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b0, KIND_MSG);
    if (me != 0) begin
      if ($urandom_range(0, 3) == 0)
        send_item(OP_POLL, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b0,
                  KIND_MSG);
      send_item(OP_WRITE, 2'(base),
                ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : FLAG_RELEASE,
                1'b0, KIND_MSG);
      send_item(OP_POLL, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b0,
                KIND_MSG);
    end
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Receiver back-pressure in bursts; none once the run is in its calm tail.
  always @(negedge clk) begin
    if (calm) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    beat_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = make_beat(m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[11:10], m_tlast);
      beats_seen++;
      if (got.kind == KIND_COMPLETE) completions_seen++;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat: %s", beat_text(got)));
      end else begin
        want = pending_beats.pop_front();
        if (got.kind !== want.kind || got.dest_node !== want.dest_node ||
            got.dest_slot !== want.dest_slot || got.msg_value !== want.msg_value ||
            got.last !== want.last || m_tdata[15:12] !== 4'h0)
          report_mismatch($sformatf("beat %0d: got %s pad %h, expected %s", beats_seen,
                                    beat_text(got), m_tdata[15:12], beat_text(want)));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding.",
               IDLE_LIMIT, pending_beats.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t        row;
    int          directed_items;
    int          target;
    int          phase_end;
    int unsigned id_pick;
    int unsigned count_pick;
    foreach (flags_q[k]) flags_q[k] = FLAG_CLEAR;

    // Reset values: a lone root completes on its first poll.
    directed_rows.push_back(typed_poll_row(KIND_COMPLETE));
    directed_rows.push_back(item_row(OP_WRITE, 2'd3, 2'd3));
    directed_rows.push_back(item_row(OP_WRITE, 2'd0, FLAG_CLEAR));
    // Leaf under the root: arrival to the parent, then waits for release.
    directed_rows.push_back(cfg_row(8'd1, 9'd3));
    directed_rows.push_back(item_row(OP_POLL, 2'd0, 2'd0));
    directed_rows.push_back(typed_poll_row(KIND_NOT_YET));
    directed_rows.push_back(item_row(OP_WRITE, 2'd2, FLAG_RELEASE));
    directed_rows.push_back(typed_poll_row(KIND_COMPLETE));
    // Root with two children; the second child is missing and the poll resumes there.
    directed_rows.push_back(cfg_row(8'd0, 9'd3));
    directed_rows.push_back(item_row(OP_WRITE, 2'd0, FLAG_ARRIVED));
    directed_rows.push_back(typed_poll_row(KIND_NOT_YET));
    directed_rows.push_back(item_row(OP_WRITE, 2'd1, FLAG_RELEASE));
    directed_rows.push_back(typed_poll_row(KIND_NOT_YET));
    directed_rows.push_back(item_row(OP_WRITE, 2'd0, FLAG_CLEAR));
    directed_rows.push_back(item_row(OP_WRITE, 2'd1, FLAG_ARRIVED));
    directed_rows.push_back(item_row(OP_POLL, 2'd0, 2'd0));
    // Inner node with both children and a count above the saturation point.
    directed_rows.push_back(cfg_row(8'd5, 9'd511));
    directed_rows.push_back(item_row(OP_WRITE, 2'd2, FLAG_ARRIVED));
    directed_rows.push_back(item_row(OP_WRITE, 2'd3, FLAG_ARRIVED));
    directed_rows.push_back(item_row(OP_POLL, 2'd0, 2'd0));
    directed_rows.push_back(item_row(OP_WRITE, 2'd2, FLAG_RELEASE));
    directed_rows.push_back(item_row(OP_POLL, 2'd0, 2'd0));
    // Zero node count with a node number outside the count.
    directed_rows.push_back(cfg_row(8'd200, 9'd0));
    directed_rows.push_back(item_row(OP_POLL, 2'd0, 2'd0));
    directed_rows.push_back(item_row(OP_WRITE, 2'd0, FLAG_RELEASE));
    directed_rows.push_back(typed_poll_row(KIND_COMPLETE));
    // Highest node number: arrival and release handled in one poll.
    directed_rows.push_back(cfg_row(8'd255, 9'd256));
    directed_rows.push_back(item_row(OP_WRITE, 2'd2, FLAG_RELEASE));
    directed_rows.push_back(item_row(OP_POLL, 2'd0, 2'd0));

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.is_cfg) begin
        drain();
        configure_node(row.id, row.count);
      end else begin
        send_item(row.op, row.slot, row.value, row.typed, row.typed_kind);
      end
    end

    directed_items = items_sent;
    target         = directed_items + RANDOM_ITEMS;
    while (items_sent < target) begin
      drain();
      case ($urandom_range(0, 3))
        0: begin
          id_pick    = ($urandom_range(0, 1) == 0) ? 0 : 255;
          count_pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                                   : $urandom_range(256, 511);
        end
        1: begin
          id_pick    = $urandom_range(0, 255);
          count_pick = $urandom_range(0, 511);
        end
        default: begin
          // Small trees, so that at least one child is present in half of these settings.
          id_pick    = $urandom_range(0, 40);
          count_pick = 2 * id_pick + $urandom_range(0, 3);
        end
      endcase
      configure_node(ID_W'(id_pick), CNT_W'(count_pick));
      phase_end = items_sent + $urandom_range(12, 28);
      while (items_sent < phase_end && items_sent < target) begin
        if (items_sent >= target - CALM_ITEMS) calm = 1'b1;
        run_episode();
      end
    end
    drain();

    $display("Sent %0d input beats (%0d polls) over %0d node settings.",
             items_sent, polls_sent, settings_used);
    $display("Checked %0d result beats, %0d of them barrier completions.",
             beats_seen, completions_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
sv/btbn_pkg.sv
sv/btbn_front.sv
sv/btbn_queue.sv
sv/btbn_back.sv
sv/binary_tree_barrier_node_core.sv
sv/btbn_checker.sv
test/binary_tree_barrier_node_core_test.sv
